[hdl/spd_pkg.sv]
// Shared types and constants of the spectrum packet deframer.
`default_nettype none
package spd_pkg;

  localparam int PACKET_BYTES = 64;
  localparam int DATA_PACKETS = 64;

  localparam logic [7:0] SYNC_BYTE = 8'h69;

  localparam int KIND_W   = 3;
  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 11;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE      = 3'd0,
    KIND_FRAME_DONE  = 3'd1,
    KIND_PREMATURE   = 3'd2,
    KIND_SYNC_MISSED = 3'd3,
    KIND_DROPPED     = 3'd4
  } kind_e;

  // One job for the back end: a status result, or a drain of one buffer half.
  typedef struct packed {
    kind_e              kind;
    logic               half;
    logic [INDEX_W-1:0] base;
  } cmd_t;

  // Back end tells the front end that a buffer half has been drained.
  typedef struct packed {
    logic valid;
    logic half;
  } back_done_t;

  // Byte write into the low or high byte buffer.
  typedef struct packed {
    logic       we_lo;
    logic       we_hi;
    logic [7:0] data;
  } ram_wr_t;

endpackage
`default_nettype wire

[hdl/spd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module spd_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[hdl/spd_front.sv]
// Front end: takes byte beats, tracks packet and byte counts, writes buffers, issues jobs.
`default_nettype none
module spd_front import spd_pkg::*; #(
  parameter int PacketBytes = PACKET_BYTES,
  parameter int DataPackets = DATA_PACKETS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [7:0]                      rx_byte_i,
  input  wire logic                            transfer_end_i,
  input  wire logic                            q_full_i,
  output logic                                 q_push_o,
  output cmd_t                                 q_cmd_o,
  input  wire back_done_t                      done_i,
  output ram_wr_t                              wr_o,
  output logic [$clog2(PacketBytes):0]         waddr_o
);

  localparam int IdxW = $clog2(PacketBytes);
  localparam int PnW  = $clog2(DataPackets + 1);
  localparam int BcW  = $clog2(PacketBytes + 2);

  logic [PnW-1:0] pn_q, pn_d;
  logic [BcW-1:0] bc_q, bc_d;
  logic [1:0]     busy_q, busy_d;

  logic           sync_phase;
  logic           accept;
  logic [BcW-1:0] bc_inc;
  logic [31:0]    base_full;

  assign sync_phase = (pn_q == PnW'(DataPackets));
  assign in_ready_o = !q_full_i && (sync_phase || !busy_q[pn_q[1]]);
  assign accept     = in_valid_i && in_ready_o;
  assign bc_inc     = (bc_q <= BcW'(PacketBytes)) ? bc_q + BcW'(1) : bc_q;
  assign base_full  = 32'(pn_q >> 1) * 32'(PacketBytes);
  assign waddr_o    = {pn_q[1], bc_q[IdxW-1:0]};

  always_comb begin
    pn_d         = pn_q;
    bc_d         = bc_q;
    busy_d       = busy_q;
    q_push_o     = 1'b0;
    q_cmd_o.kind = KIND_DROPPED;
    q_cmd_o.half = pn_q[1];
    q_cmd_o.base = base_full[INDEX_W-1:0];
    wr_o.we_lo   = 1'b0;
    wr_o.we_hi   = 1'b0;
    wr_o.data    = rx_byte_i;

    if (done_i.valid) begin
      busy_d[done_i.half] = 1'b0;
    end

    if (accept) begin
      if (sync_phase) begin
        // decide on the first byte, swallow the rest of the transfer
        if (bc_q == '0) begin
          q_push_o     = 1'b1;
          q_cmd_o.kind = (rx_byte_i == SYNC_BYTE) ? KIND_FRAME_DONE : KIND_SYNC_MISSED;
          bc_d         = BcW'(1);
        end
        if (transfer_end_i) begin
          pn_d = '0;
          bc_d = '0;
        end
      end else begin
        if (bc_q < BcW'(PacketBytes)) begin
          wr_o.we_lo = !pn_q[0];
          wr_o.we_hi = pn_q[0];
        end
        if (!transfer_end_i) begin
          bc_d = bc_inc;
        end else begin
          bc_d = '0;
          if (bc_inc == BcW'(PacketBytes)) begin
            if (pn_q[0]) begin
              q_push_o          = 1'b1;
              q_cmd_o.kind      = KIND_SAMPLE;
              busy_d[pn_q[1]]   = 1'b1;
            end
            pn_d = pn_q + PnW'(1);
          end else if ((bc_q == '0) && (rx_byte_i == SYNC_BYTE)) begin
            q_push_o     = 1'b1;
            q_cmd_o.kind = KIND_PREMATURE;
            pn_d         = '0;
          end else begin
            q_push_o     = 1'b1;
            q_cmd_o.kind = KIND_DROPPED;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_q   <= '0;
      bc_q   <= '0;
      busy_q <= '0;
    end else begin
      pn_q   <= pn_d;
      bc_q   <= bc_d;
      busy_q <= busy_d;
    end
  end

endmodule
`default_nettype wire

[hdl/spd_queue.sv]
// Short job queue between front and back end.
`default_nettype none
module spd_queue import spd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      head_o
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  logic do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[hdl/spd_back.sv]
// Back end: carries out jobs, drains buffer halves into samples, drives the result register.
`default_nettype none
module spd_back import spd_pkg::*; #(
  parameter int PacketBytes = PACKET_BYTES
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_valid_i,
  input  wire cmd_t                        q_head_i,
  output logic                             q_pop_o,
  output back_done_t                       done_o,
  output logic                             re_o,
  output logic [$clog2(PacketBytes):0]     raddr_o,
  input  wire logic [7:0]                  rdata_lo_i,
  input  wire logic [7:0]                  rdata_hi_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [KIND_W-1:0]                kind_o,
  output logic [SAMPLE_W-1:0]              sample_o,
  output logic [INDEX_W-1:0]               sample_index_o,
  output logic                             last_o
);

  localparam int IdxW = $clog2(PacketBytes);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic                half_q, half_d;
  logic [INDEX_W-1:0]  base_q, base_d;

  logic                out_valid_q, out_valid_d;
  kind_e               out_kind_q, out_kind_d;
  logic [SAMPLE_W-1:0] out_sample_q, out_sample_d;
  logic [INDEX_W-1:0]  out_index_q, out_index_d;
  logic                out_last_q, out_last_d;

  logic slot_free;
  logic load;
  logic idx_last;

  assign slot_free = !out_valid_q || out_ready_i;
  assign idx_last  = (idx_q == IdxW'(PacketBytes - 1));
  assign raddr_o   = {half_q, idx_q};

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    half_d       = half_q;
    base_d       = base_q;
    q_pop_o      = 1'b0;
    re_o         = 1'b0;
    done_o.valid = 1'b0;
    done_o.half  = half_q;
    load         = 1'b0;
    out_kind_d   = out_kind_q;
    out_sample_d = out_sample_q;
    out_index_d  = out_index_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_head_i.kind == KIND_SAMPLE) begin
            q_pop_o = 1'b1;
            half_d  = q_head_i.half;
            base_d  = q_head_i.base;
            idx_d   = '0;
            state_d = ST_READ;
          end else if (slot_free) begin
            q_pop_o      = 1'b1;
            load         = 1'b1;
            out_kind_d   = q_head_i.kind;
            out_sample_d = '0;
            out_index_d  = '0;
            out_last_d   = 1'b1;
          end
        end
      end
      ST_READ: begin
        re_o    = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // read data holds until the result register frees up
        if (slot_free) begin
          load         = 1'b1;
          out_kind_d   = KIND_SAMPLE;
          out_sample_d = {rdata_hi_i, rdata_lo_i};
          out_index_d  = base_q + INDEX_W'(idx_q);
          out_last_d   = idx_last;
          if (idx_last) begin
            done_o.valid = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    half_q       <= half_d;
    base_q       <= base_d;
    out_kind_q   <= out_kind_d;
    out_sample_q <= out_sample_d;
    out_index_q  <= out_index_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign sample_o       = out_sample_q;
  assign sample_index_o = out_index_q;
  assign last_o         = out_last_q;

endmodule
`default_nettype wire

[hdl/spectrum_packet_deframer.sv]
// Top level of the spectrum packet deframer.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_ready_o   rx_byte_i, transfer_end_i
//   out      source     out_valid_o/out_ready_i kind_o, sample_o, sample_index_o, last_o
//
// Status results are loaded into the result register when it is free. Each sample takes
// a read-then-emit step of the shared buffer read port; the emit waits for a free result
// register. The byte buffers hold two halves of one packet pair each, so a pair is
// received while the previous one drains. Input stalls while the job queue is full or
// while the half to be written still waits to be drained.
// Reset clears counters, pointers and the result valid; buffer contents are not cleared.
`default_nettype none
module spectrum_packet_deframer import spd_pkg::*; #(
  parameter int PacketBytes = PACKET_BYTES,
  parameter int DataPackets = DATA_PACKETS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          rx_byte_i,
  input  wire logic                transfer_end_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [KIND_W-1:0]        kind_o,
  output logic [SAMPLE_W-1:0]      sample_o,
  output logic [INDEX_W-1:0]       sample_index_o,
  output logic                     last_o
);

  localparam int IdxW     = $clog2(PacketBytes);
  localparam int RamDepth = 2 * (2 ** IdxW);

  logic          q_full, q_push, q_valid, q_pop;
  cmd_t          q_cmd, q_head;
  back_done_t    done;
  ram_wr_t       wr;
  logic [IdxW:0] waddr, raddr;
  logic          re;
  logic [7:0]    rdata_lo, rdata_hi;

  spd_front #(
    .PacketBytes (PacketBytes),
    .DataPackets (DataPackets)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .transfer_end_i (transfer_end_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cmd_o        (q_cmd),
    .done_i         (done),
    .wr_o           (wr),
    .waddr_o        (waddr)
  );

  spd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  spd_ram #(
    .Width (8),
    .Depth (RamDepth)
  ) u_ram_lo (
    .clk_i   (clk_i),
    .we_i    (wr.we_lo),
    .waddr_i (waddr),
    .wdata_i (wr.data),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata_lo)
  );

  spd_ram #(
    .Width (8),
    .Depth (RamDepth)
  ) u_ram_hi (
    .clk_i   (clk_i),
    .we_i    (wr.we_hi),
    .waddr_i (waddr),
    .wdata_i (wr.data),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata_hi)
  );

  spd_back #(
    .PacketBytes (PacketBytes)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .done_o         (done),
    .re_o           (re),
    .raddr_o        (raddr),
    .rdata_lo_i     (rdata_lo),
    .rdata_hi_i     (rdata_hi),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .sample_o       (sample_o),
    .sample_index_o (sample_index_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire
